/* hdl/dqmr_pkg.sv */
// shared types and constants for the linked-list deque with middle tracking
// no dependencies; imported by every module of the block
`default_nettype none

package dqmr_pkg;

    // default node storage depth
    localparam int CAPACITY_DEF = 1024;

    // fixed field widths
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 11;
    localparam int MIDPOS_W = 10;

    // request codes
    localparam logic [ACTION_W-1:0] ACT_PUSH_HEAD = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_TAIL = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_HEAD  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_TAIL  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ROTATE    = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // request word
    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value_in;
    } t_req;

    // response word
    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic [STATUS_W-1:0]       status;
        logic [SIZE_W-1:0]         size;
        logic [MIDPOS_W-1:0]       middle_position;
    } t_rsp;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch request word and launch pointer reads
        logic execute;  // write back links, update state, load response
    } t_dq_cmd;

endpackage

`default_nettype wire

/* hdl/dqmr_ctrl.sv */
// sequencer for the deque: request handshake, two-step operation, response valid
// depends on dqmr_pkg
`default_nettype none

module dqmr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_ready,
    output dqmr_pkg::t_dq_cmd      o_cmd
);
    import dqmr_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;

    // commands
    always_comb begin
        o_req_ready   = (r_state == S_IDLE);
        o_cmd.capture = (r_state == S_IDLE) && i_req_valid;
        o_cmd.execute = (r_state == S_EXEC) && (!r_rsp_valid || i_rsp_ready);
    end

    // next state and response valid
    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.execute) begin
                    n_state     = S_IDLE;
                    n_rsp_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

`default_nettype wire

/* hdl/dqmr_dpath.sv */
// datapath for the deque: node memories, free stack, list registers, response register
// depends on dqmr_pkg
`default_nettype none

module dqmr_dpath #(
    parameter int CAPACITY = dqmr_pkg::CAPACITY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dqmr_pkg::t_dq_cmd  i_cmd,
    input  wire dqmr_pkg::t_req     i_req,
    output dqmr_pkg::t_rsp          o_rsp
);
    import dqmr_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // node storage and free stack
    logic signed [VALUE_W-1:0] mem_value [CAPACITY];
    logic [IW-1:0]             mem_next  [CAPACITY];
    logic [IW-1:0]             mem_prev  [CAPACITY];
    logic [IW-1:0]             mem_free  [CAPACITY];

    // list state
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [IW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_free_top, n_free_top;
    logic [CW-1:0] r_fresh, n_fresh;

    // captured request and read data
    logic [ACTION_W-1:0]       r_action;
    logic signed [VALUE_W-1:0] r_value_in;
    logic signed [VALUE_W-1:0] r_val_q;
    logic [IW-1:0]             r_fs_q;
    logic [IW-1:0]             r_nh_q;
    logic [IW-1:0]             r_nm_q;
    logic [IW-1:0]             r_pt_q;
    logic [IW-1:0]             r_pm_q;

    logic [CW-1:0] w_ft_m1;
    logic [IW-1:0] w_victim_rd;

    // write-back controls
    logic                      w_val_we, w_next_we, w_prev_we, w_free_we;
    logic [IW-1:0]             w_val_addr, w_next_addr, w_prev_addr, w_free_addr;
    logic [IW-1:0]             w_next_data, w_prev_data, w_free_data;
    logic signed [VALUE_W-1:0] w_value_out;
    logic [STATUS_W-1:0]       w_status;

    logic          w_full, w_empty;
    logic [IW-1:0] w_slot, w_victim;
    logic [CW-1:0] w_cnt_inc, w_cnt_dec;

    assign w_ft_m1     = r_free_top - CW'(1);
    assign w_victim_rd = (i_req.action == ACT_POP_TAIL) ? r_tail : r_head;

    // launch all pointer and value reads at capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action   <= i_req.action;
            r_value_in <= i_req.value_in;
            r_val_q    <= mem_value[w_victim_rd];
            r_fs_q     <= mem_free[w_ft_m1[IW-1:0]];
            r_nh_q     <= mem_next[r_head];
            r_nm_q     <= mem_next[r_mid];
            r_pt_q     <= mem_prev[r_tail];
            r_pm_q     <= mem_prev[r_mid];
        end
    end

    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_slot    = (r_free_top != '0) ? r_fs_q : r_fresh[IW-1:0];
    assign w_victim  = (r_action == ACT_POP_TAIL) ? r_tail : r_head;
    assign w_cnt_inc = r_count + CW'(1);
    assign w_cnt_dec = r_count - CW'(1);

    // operation decode and link update
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_mid       = r_mid;
        n_count     = r_count;
        n_pos       = r_pos;
        n_free_top  = r_free_top;
        n_fresh     = r_fresh;
        w_val_we    = 1'b0;
        w_next_we   = 1'b0;
        w_prev_we   = 1'b0;
        w_free_we   = 1'b0;
        w_val_addr  = w_slot;
        w_next_addr = '0;
        w_next_data = '0;
        w_prev_addr = '0;
        w_prev_data = '0;
        w_free_addr = r_free_top[IW-1:0];
        w_free_data = w_victim;
        w_value_out = '0;
        w_status    = ST_OK;
        case (r_action)
            ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    // take a recycled slot first, else the next fresh one
                    if (r_free_top != '0) begin
                        n_free_top = w_ft_m1;
                    end else begin
                        n_fresh = r_fresh + CW'(1);
                    end
                    w_val_we = 1'b1;
                    if (w_empty) begin
                        n_head  = w_slot;
                        n_tail  = w_slot;
                        n_mid   = w_slot;
                        n_count = CW'(1);
                        n_pos   = CW'(1);
                    end else if (r_action == ACT_PUSH_HEAD) begin
                        w_prev_we   = 1'b1;
                        w_prev_addr = r_head;
                        w_prev_data = w_slot;
                        w_next_we   = 1'b1;
                        w_next_addr = w_slot;
                        w_next_data = r_head;
                        n_head      = w_slot;
                        n_count     = w_cnt_inc;
                        // middle steps back one node or its position moves up
                        if ((w_cnt_inc >> 1) != r_pos) begin
                            n_mid = r_pm_q;
                        end else begin
                            n_pos = r_pos + CW'(1);
                        end
                    end else begin
                        w_next_we   = 1'b1;
                        w_next_addr = r_tail;
                        w_next_data = w_slot;
                        w_prev_we   = 1'b1;
                        w_prev_addr = w_slot;
                        w_prev_data = r_tail;
                        n_tail      = w_slot;
                        n_count     = w_cnt_inc;
                        if (r_pos != (w_cnt_inc >> 1) + CW'(1)) begin
                            // middle at the tail advances onto the new node
                            n_mid = (r_mid == r_tail) ? w_slot : r_nm_q;
                            n_pos = r_pos + CW'(1);
                        end
                    end
                end
            end
            ACT_POP_HEAD, ACT_POP_TAIL: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_value_out = r_val_q;
                    // return the slot to the free stack
                    if (r_free_top < CW'(CAPACITY)) begin
                        w_free_we  = 1'b1;
                        n_free_top = r_free_top + CW'(1);
                    end
                    if (r_count == CW'(1)) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_mid   = '0;
                        n_count = '0;
                        n_pos   = '0;
                    end else if (r_action == ACT_POP_HEAD) begin
                        n_head  = r_nh_q;
                        n_count = w_cnt_dec;
                        if (r_pos != (w_cnt_dec >> 1) + CW'(2)) begin
                            n_mid = r_nm_q;
                        end else begin
                            n_pos = r_pos - CW'(1);
                        end
                    end else begin
                        n_tail  = r_pt_q;
                        n_count = w_cnt_dec;
                        if (r_pos != (w_cnt_dec >> 1) + CW'(1)) begin
                            n_mid = r_pm_q;
                            n_pos = r_pos - CW'(1);
                        end
                    end
                end
            end
            ACT_ROTATE: begin
                // close the ring, then cut it in front of the middle node
                if (r_count >= CW'(2)) begin
                    w_prev_we   = 1'b1;
                    w_prev_addr = r_head;
                    w_prev_data = r_tail;
                    w_next_we   = 1'b1;
                    w_next_addr = r_tail;
                    w_next_data = r_head;
                    n_head      = r_mid;
                    n_tail      = r_pm_q;
                    n_mid       = r_count[0] ? r_tail : r_head;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // memory write-back
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && w_val_we) begin
            mem_value[w_val_addr] <= r_value_in;
        end
        if (i_cmd.execute && w_next_we) begin
            mem_next[w_next_addr] <= w_next_data;
        end
        if (i_cmd.execute && w_prev_we) begin
            mem_prev[w_prev_addr] <= w_prev_data;
        end
        if (i_cmd.execute && w_free_we) begin
            mem_free[w_free_addr] <= w_free_data;
        end
    end

    // list state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_mid      <= '0;
            r_count    <= '0;
            r_pos      <= '0;
            r_free_top <= '0;
            r_fresh    <= '0;
        end else if (i_cmd.execute) begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_mid      <= n_mid;
            r_count    <= n_count;
            r_pos      <= n_pos;
            r_free_top <= n_free_top;
            r_fresh    <= n_fresh;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            o_rsp.value_out       <= w_value_out;
            o_rsp.status          <= w_status;
            o_rsp.size            <= SIZE_W'(n_count);
            o_rsp.middle_position <= MIDPOS_W'(n_pos);
        end
    end

endmodule

`default_nettype wire

/* hdl/deque_with_middle_and_half_rotate.sv */
// linked-list deque with tracked middle node and half rotation
// sequence: an accepted request word is captured, then executed, then its response
//   is registered as valid; execution waits while an earlier response is still waiting
// overlap: no new request is accepted until the captured word has executed, since
//   the neighbor pointers are read into registers before the links are written back
// reset: list registers and free stack pointers clear at once; node memories
//   are not cleared and need no clearing pass
`default_nettype none

module deque_with_middle_and_half_rotate #(
    parameter int CAPACITY = dqmr_pkg::CAPACITY_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire dqmr_pkg::t_req  i_req,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    output dqmr_pkg::t_rsp       o_rsp
);
    import dqmr_pkg::*;

    t_dq_cmd w_cmd;

    // sequencer
    dqmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_cmd       (w_cmd)
    );

    // storage and list update
    dqmr_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    // a captured word blocks new requests until it is executed
    a_capture_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture |=> !o_req_ready)
        else $error("request accepted while a word is in flight");

    // an executed word always shows up as a valid response
    a_execute_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.execute |=> o_rsp_valid)
        else $error("executed word did not produce a response");

    // capture and execute never overlap
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.capture && w_cmd.execute))
        else $error("capture and execute in the same cycle");

    // a pop on an empty list returns zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status == ST_EMPTY)) |-> (o_rsp.value_out == '0))
        else $error("empty pop returned a nonzero word");

endmodule

`default_nettype wire
